// ===== rtl/core/cfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg - shared definitions for the checked frame deframer
// Frame layout constants, status codes and the result record that travels
// from the checking core to the output register.
// ----------------------------------------------------------------------------
package cfd_pkg;

  // Frame layout
  localparam int MIN_FRAME     = 8;
  localparam int TRAILER_BYTES = 4;
  localparam int HEADER_BYTES  = 3;
  localparam int MAX_FRAME_DEF = 1024;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int ID_W      = 16;
  localparam int SUM_W     = 32;
  localparam int PAY_LEN_W = 10;
  localparam int OUT_DATA_W = 40;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_ROOM  = 2'd2,
    ST_SUM   = 2'd3
  } status_t;

  // One result item
  typedef struct packed {
    logic                 payload_valid;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 frame_done;
    status_t              status;
    logic [ID_W-1:0]      message_id;
    logic [PAY_LEN_W-1:0] payload_length;
  } result_t;

endpackage

// ===== rtl/core/cfd_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_in_reg - input register
// Captures one received byte and its last flag; holds it until the core
// consumes it.
// ----------------------------------------------------------------------------
module cfd_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cfd_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_last,
  input  logic                      consume,
  output logic                      hold_valid,
  output logic [cfd_pkg::BYTE_W-1:0] hold_byte,
  output logic                      hold_last
);

  logic                       vld_r;
  logic                       vld_nxt;
  logic [cfd_pkg::BYTE_W-1:0] byte_r;
  logic                       last_r;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready = !vld_r || consume;
  assign vld_nxt  = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  assign hold_valid = vld_r;
  assign hold_byte  = byte_r;
  assign hold_last  = last_r;

endmodule

// ===== rtl/core/cfd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_core - per-byte frame checker
// Tracks position, room byte, id bytes, payload sum and the four-byte delay
// line; forms the result item for the byte held in the input register.
// ----------------------------------------------------------------------------
module cfd_core #(
  parameter int MAX_FRAME = cfd_pkg::MAX_FRAME_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [cfd_pkg::BYTE_W-1:0] data_byte,
  input  logic                       last_byte,
  input  logic [cfd_pkg::BYTE_W-1:0] room_id,
  output logic                       res_valid,
  output cfd_pkg::result_t           res
);

  localparam int POS_W = $clog2(MAX_FRAME + 1);
  localparam int LW    = (POS_W > cfd_pkg::PAY_LEN_W) ? POS_W : cfd_pkg::PAY_LEN_W;
  localparam int RELEASE_POS = cfd_pkg::HEADER_BYTES + cfd_pkg::TRAILER_BYTES;
  localparam int LEN_MAX = (1 << cfd_pkg::PAY_LEN_W) - 1;

  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [cfd_pkg::BYTE_W-1:0]    room_r, room_nxt;
  logic [cfd_pkg::ID_W-1:0]      id_r, id_nxt;
  logic [cfd_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [cfd_pkg::BYTE_W-1:0]    dly_r [4];
  logic [cfd_pkg::BYTE_W-1:0]    dly_nxt [4];

  logic                          released;
  logic [POS_W-1:0]              count;
  logic [LW-1:0]                 len_full;
  logic [cfd_pkg::PAY_LEN_W-1:0] len;
  logic [cfd_pkg::SUM_W-1:0]     trailer;
  cfd_pkg::status_t              status;

  // Update frame fields for the current byte
  always_comb begin
    room_nxt   = room_r;
    id_nxt     = id_r;
    sum_nxt    = sum_r;
    dly_nxt    = dly_r;
    released   = 1'b0;
    if (pos_r == POS_W'(0)) begin
      room_nxt = data_byte;
    end else if (pos_r == POS_W'(1)) begin
      id_nxt = {id_r[15:8], data_byte};
    end else if (pos_r == POS_W'(2)) begin
      id_nxt = {data_byte, id_r[7:0]};
    end else begin
      if (pos_r >= POS_W'(RELEASE_POS)) begin
        released = 1'b1;
        sum_nxt  = sum_r + {24'd0, dly_r[0]};
      end
      dly_nxt[0] = dly_r[1];
      dly_nxt[1] = dly_r[2];
      dly_nxt[2] = dly_r[3];
      dly_nxt[3] = data_byte;
    end
  end

  // Saturate the byte count
  assign count = (pos_r == POS_W'(MAX_FRAME)) ? pos_r : pos_r + POS_W'(1);

  // Length and trailer for the end-of-frame report
  assign len_full = LW'(count) - LW'(RELEASE_POS);
  assign len      = (len_full > LW'(LEN_MAX)) ? cfd_pkg::PAY_LEN_W'(LEN_MAX)
                                              : len_full[cfd_pkg::PAY_LEN_W-1:0];
  assign trailer  = {dly_nxt[3], dly_nxt[2], dly_nxt[1], dly_nxt[0]};

  // Pick status: short, then wrong room, then checksum
  always_comb begin
    if (count < POS_W'(cfd_pkg::MIN_FRAME)) begin
      status = cfd_pkg::ST_SHORT;
    end else if (room_r != room_id) begin
      status = cfd_pkg::ST_ROOM;
    end else if (trailer != sum_nxt) begin
      status = cfd_pkg::ST_SUM;
    end else begin
      status = cfd_pkg::ST_OK;
    end
  end

  // Form the result item
  always_comb begin
    res_valid          = released || last_byte;
    res.payload_valid  = released;
    res.payload_byte   = released ? dly_r[0] : '0;
    res.frame_done     = last_byte;
    res.status         = last_byte ? status : cfd_pkg::ST_OK;
    res.message_id     = last_byte ? id_nxt : '0;
    res.payload_length = (last_byte && status != cfd_pkg::ST_SHORT) ? len : '0;
  end

  assign pos_nxt = count;

  // Advance state; clear the frame after its last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      room_r <= '0;
      id_r   <= '0;
      sum_r  <= '0;
      for (int i = 0; i < 4; i++) dly_r[i] <= '0;
    end else if (advance) begin
      if (last_byte) begin
        pos_r  <= '0;
        room_r <= '0;
        id_r   <= '0;
        sum_r  <= '0;
        for (int i = 0; i < 4; i++) dly_r[i] <= '0;
      end else begin
        pos_r  <= pos_nxt;
        room_r <= room_nxt;
        id_r   <= id_nxt;
        sum_r  <= sum_nxt;
        dly_r  <= dly_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/cfd_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_out_reg - result register
// Holds one result item until the consumer takes it; frees itself in the
// same cycle it is taken.
// ----------------------------------------------------------------------------
module cfd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cfd_pkg::result_t load_res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output cfd_pkg::result_t out_res
);

  logic             vld_r;
  logic             vld_nxt;
  cfd_pkg::result_t res_r;

  // Slot is free when empty or being drained
  assign free    = !vld_r || out_ready;
  assign vld_nxt = load ? 1'b1 : (out_ready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/core/checked_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_frame_deframer_top - received frame checker
// Checks room byte and 32-bit sum trailer of byte-serial frames; reports message id.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle unless the result channel stalls;
// each accepted byte passes an input register, the per-byte checker (one
// 32-bit add and one trailer compare), and a result register. Each byte from
// position 7 on releases the byte four positions back as a tentative payload
// item (tuser high); the last byte's item carries tlast with the status,
// message id and payload length. Keep the released bytes only if that status
// is ok. Bytes that release nothing and do not end a frame give no result.
// Write room_id only while no frame is in flight.
module checked_frame_deframer_top #(
  parameter int MAX_FRAME = cfd_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] payload_byte, [9:8] status,
                                  // [25:10] message_id, [35:26] payload_length
  output logic        out_tuser,  // payload_valid
  output logic        out_tlast,  // frame_done
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data // room_id
);

  logic                       hold_valid;
  logic [cfd_pkg::BYTE_W-1:0] hold_byte;
  logic                       hold_last;
  logic                       advance;
  logic                       slot_free;
  logic                       res_valid;
  cfd_pkg::result_t           res;
  cfd_pkg::result_t           out_res;
  logic [cfd_pkg::BYTE_W-1:0] room_id_r;

  // Room id register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_id_r <= '0;
    end else if (cfg_wr_en) begin
      room_id_r <= cfg_wr_data;
    end
  end

  // Move the held byte when the result slot can take its item
  assign advance = hold_valid && slot_free;

  cfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .consume    (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .hold_last  (hold_last)
  );

  cfd_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .data_byte (hold_byte),
    .last_byte (hold_last),
    .room_id   (room_id_r),
    .res_valid (res_valid),
    .res       (res)
  );

  cfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .load_res  (res),
    .free      (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result item
  assign out_tdata = {4'd0, out_res.payload_length, out_res.message_id,
                      out_res.status, out_res.payload_byte};
  assign out_tuser = out_res.payload_valid;
  assign out_tlast = out_res.frame_done;

endmodule
